### sv/cbs_pkg.sv
package cbs_pkg;

  // Table geometry: four banks so that the four neighbor points of a segment
  // always land in different banks.
  localparam int MaxPoints = 64;
  localparam int NumBanks  = 4;
  localparam int BankRows  = MaxPoints / NumBanks;
  localparam int RowW      = $clog2(BankRows);

  // Reciprocal of three for an exact floor division of values below 2^33.
  localparam logic [31:0] RecipThree = 32'd2863311531;

  localparam logic [6:0] NumPointsReset = 7'd4;
  localparam logic [6:0] NumPointsMax   = 7'(MaxPoints);

  typedef enum logic {
    CmdWrite = 1'b0,
    CmdEval  = 1'b1
  } cmd_e;

  typedef enum logic {
    StatOk  = 1'b0,
    StatErr = 1'b1
  } stat_e;

  typedef struct packed {
    logic signed [31:0] z;
    logic signed [31:0] y;
    logic signed [31:0] x;
  } pt_t;

  // Evaluate beat after the table read.
  typedef struct packed {
    pt_t [3:0]   pts;
    logic [15:0] u;
    logic        err;
  } eval_t;

  // Evaluate beat with both weight sets.
  typedef struct packed {
    pt_t [3:0]                pts;
    logic signed [3:0][31:0]  wp;
    logic signed [3:0][31:0]  wd;
    logic                     err;
  } wbeat_t;

  typedef struct packed {
    logic signed [31:0] tan_z;
    logic signed [31:0] tan_y;
    logic signed [31:0] tan_x;
    logic signed [31:0] pos_z;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_x;
  } res_t;

endpackage

### sv/cubic_bspline_point_tangent.sv
// Uniform cubic B-spline point and tangent evaluator. Write beats (tuser 0)
// store one Q16.16 control point and give no result; evaluate beats (tuser 1)
// return the curve point and its derivative for segment i at t, blended from
// points i-1 .. i+2, with status 1 and zero values for a segment outside
// 1 .. min(num_points, 64)-3. The block takes one beat per clock unless
// m_axis_tready holds it back. Evaluate results pass eight register stages:
// a banked table read loaded on the accepting edge, four weight stages
// (squares, cubes, basis, divide by three) and three blend stages (multiply,
// pair sums, round and saturate). A point written by one beat may be read
// by the very next beat. Reading a slot never written gives undefined values.
// num_points resets to 4. The user must see that it is written through cfg_we_i
// only while the block is idle; the block itself does not enforce this.
module cubic_bspline_point_tangent import cbs_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [6:0]   cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [5:0] point_index, [37:6] coord_x, [69:38] coord_y, [101:70] coord_z,
  // [107:102] segment, [123:108] param_t, [127:124] zero
  input  logic [127:0] s_axis_tdata,
  // [0] cmd
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] pos_x, [63:32] pos_y, [95:64] pos_z, [127:96] tan_x,
  // [159:128] tan_y, [191:160] tan_z
  output logic [191:0] m_axis_tdata,
  // [0] status
  output logic         m_axis_tuser
);

  logic [6:0] num_points_q;
  pt_t        coord;
  logic       mem_valid, mem_ready, wt_valid, wt_ready;
  eval_t      mem_beat;
  wbeat_t     wt_beat;
  res_t       res;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_points_q <= NumPointsReset;
    end else if (cfg_we_i) begin
      num_points_q <= cfg_wdata_i;
    end
  end

  assign coord.x = s_axis_tdata[37:6];
  assign coord.y = s_axis_tdata[69:38];
  assign coord.z = s_axis_tdata[101:70];

  cbs_point_mem u_mem (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .cmd_i         (s_axis_tuser),
    .point_index_i (s_axis_tdata[5:0]),
    .coord_i       (coord),
    .segment_i     (s_axis_tdata[107:102]),
    .param_t_i     (s_axis_tdata[123:108]),
    .num_points_i  (num_points_q),
    .out_valid_o   (mem_valid),
    .out_ready_i   (mem_ready),
    .out_o         (mem_beat)
  );

  cbs_weights u_weights (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mem_valid),
    .in_ready_o  (mem_ready),
    .in_i        (mem_beat),
    .out_valid_o (wt_valid),
    .out_ready_i (wt_ready),
    .out_o       (wt_beat)
  );

  cbs_blend u_blend (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (wt_valid),
    .in_ready_o  (wt_ready),
    .in_i        (wt_beat),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res),
    .status_o    (m_axis_tuser)
  );

  assign m_axis_tdata = res;

endmodule

### sv/cbs_point_mem.sv
module cbs_point_mem import cbs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [5:0]  point_index_i,
  input  pt_t         coord_i,
  input  logic [5:0]  segment_i,
  input  logic [15:0] param_t_i,
  input  logic [6:0]  num_points_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output eval_t       out_o
);

  logic [95:0] bank_q [NumBanks][BankRows];
  logic [95:0] rd_q [NumBanks];
  logic [1:0]  rot_q;
  logic [15:0] u_q;
  logic        err_q;
  logic        v_q;
  logic        en, acc, wr, ev;
  logic [5:0]  base;
  logic [6:0]  limit, seg_end;
  logic        err;
  logic [RowW-1:0] row [NumBanks];

  assign en         = !v_q || out_ready_i;
  assign in_ready_o = en;
  assign acc        = in_valid_i && en;
  assign wr         = acc && (cmd_e'(cmd_i) == CmdWrite);
  assign ev         = acc && (cmd_e'(cmd_i) == CmdEval);

  // Segment range check against the active point count.
  assign limit   = (num_points_i > NumPointsMax) ? NumPointsMax : num_points_i;
  assign seg_end = {1'b0, segment_i} + 7'd3;
  assign err     = (segment_i == 6'd0) || (seg_end > limit);

  // Each bank holds exactly one of the points i-1 .. i+2.
  assign base = segment_i - 6'd1;
  always_comb begin
    for (int b = 0; b < NumBanks; b++) begin
      logic [1:0] off;
      logic [5:0] j;
      off    = 2'(b) - base[1:0];
      j      = base + {4'b0, off};
      row[b] = j[5:2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= ev;
    end
  end

  // Table write and banked read.
  always_ff @(posedge clk_i) begin
    for (int b = 0; b < NumBanks; b++) begin
      if (wr && point_index_i[1:0] == 2'(b)) begin
        bank_q[b][point_index_i[5:2]] <= coord_i;
      end
    end
    if (ev) begin
      for (int b = 0; b < NumBanks; b++) begin
        rd_q[b] <= bank_q[b][row[b]];
      end
      rot_q <= base[1:0];
      u_q   <= param_t_i;
      err_q <= err;
    end
  end

  // Put the points back in curve order.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      out_o.pts[k] = rd_q[rot_q + 2'(k)];
    end
    out_o.u   = u_q;
    out_o.err = err_q;
  end

  assign out_valid_o = v_q;

endmodule

### sv/cbs_weights.sv
module cbs_weights import cbs_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  eval_t  in_i,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output wbeat_t out_o
);

  logic [3:0] v_q;
  logic [3:0] en;

  // Stage 1: squares.
  logic [15:0] u1_q;
  logic [16:0] s1_q;
  logic [31:0] u2_1_q;
  logic [32:0] s2_1_q;
  pt_t [3:0]   pts1_q;
  logic        err1_q;
  // Stage 2: cubes and derivative weights.
  logic [15:0] u2s_q;
  logic [31:0] u2_2_q;
  logic [47:0] u3_2_q;
  logic [48:0] s3_2_q;
  logic signed [3:0][31:0] wd2_q, wd3_q, wd4_q;
  pt_t [3:0]   pts2_q, pts3_q, pts4_q;
  logic        err2_q, err3_q, err4_q;
  // Stage 3: position numerators scaled down by 2^19.
  logic [3:0][31:0] y3_q;
  // Stage 4: division by three.
  logic signed [3:0][31:0] wp4_q;

  logic [16:0] s_d;
  logic [33:0] s2_full;
  logic [49:0] s3_full;
  logic signed [35:0] dk [4];
  logic signed [35:0] dr [4];
  logic signed [52:0] ak [4];
  logic signed [52:0] ar [4];
  logic [3:0][31:0] y_d;
  logic [3:0][31:0] wp_d;

  // Each stage moves when it is empty or the next one moves.
  assign en[3] = !v_q[3] || out_ready_i;
  assign en[2] = !v_q[2] || en[3];
  assign en[1] = !v_q[1] || en[2];
  assign en[0] = !v_q[0] || en[1];
  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      if (en[1]) v_q[1] <= v_q[0];
      if (en[2]) v_q[2] <= v_q[1];
      if (en[3]) v_q[3] <= v_q[2];
    end
  end

  assign s_d     = 17'h10000 - {1'b0, in_i.u};
  assign s2_full = s_d * s_d;
  assign s3_full = s2_1_q * s1_q;

  // Derivative basis at scale 2^33, rounded to Q2.30.
  always_comb begin
    logic signed [35:0] u2e, ue;
    u2e   = $signed({4'b0, u2_1_q});
    ue    = $signed({20'b0, u1_q});
    dk[0] = -$signed({3'b0, s2_1_q});
    dk[1] = 36'(3 * u2e) - (ue <<< 18);
    dk[2] = -36'(3 * u2e) + (ue <<< 17) + (36'sd1 <<< 32);
    dk[3] = u2e;
    for (int k = 0; k < 4; k++) begin
      dr[k] = (dk[k] + 36'sd4) >>> 3;
    end
  end

  // Position basis at scale 6 * 2^48, then floor((A + 3*2^18) / 2^19).
  always_comb begin
    logic signed [52:0] u3e, u2e, ue;
    u3e   = $signed({5'b0, u3_2_q});
    u2e   = $signed({21'b0, u2_2_q});
    ue    = $signed({37'b0, u2s_q});
    ak[0] = $signed({4'b0, s3_2_q});
    ak[1] = 53'(3 * u3e) - 53'(6 * (u2e <<< 16)) + (53'sd4 <<< 48);
    ak[2] = -53'(3 * u3e) + 53'(3 * (u2e <<< 16)) + 53'(3 * (ue <<< 32))
            + (53'sd1 <<< 48);
    ak[3] = u3e;
    for (int k = 0; k < 4; k++) begin
      ar[k]  = ak[k] + (53'sd3 <<< 18);
      y_d[k] = ar[k][50:19];
    end
  end

  // The reciprocal product gives the exact quotient by three.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      logic [63:0] prod;
      prod     = y3_q[k] * RecipThree;
      wp_d[k]  = {1'b0, prod[63:33]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      u1_q   <= in_i.u;
      s1_q   <= s_d;
      u2_1_q <= in_i.u * in_i.u;
      s2_1_q <= s2_full[32:0];
      pts1_q <= in_i.pts;
      err1_q <= in_i.err;
    end
    if (en[1]) begin
      u2s_q  <= u1_q;
      u2_2_q <= u2_1_q;
      u3_2_q <= u2_1_q * u1_q;
      s3_2_q <= s3_full[48:0];
      for (int k = 0; k < 4; k++) wd2_q[k] <= dr[k][31:0];
      pts2_q <= pts1_q;
      err2_q <= err1_q;
    end
    if (en[2]) begin
      y3_q   <= y_d;
      wd3_q  <= wd2_q;
      pts3_q <= pts2_q;
      err3_q <= err2_q;
    end
    if (en[3]) begin
      wp4_q  <= wp_d;
      wd4_q  <= wd3_q;
      pts4_q <= pts3_q;
      err4_q <= err3_q;
    end
  end

  assign out_valid_o = v_q[3];
  assign out_o.pts   = pts4_q;
  assign out_o.wp    = wp4_q;
  assign out_o.wd    = wd4_q;
  assign out_o.err   = err4_q;

endmodule

### sv/cbs_blend.sv
module cbs_blend import cbs_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  wbeat_t in_i,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output res_t   out_o,
  output logic   status_o
);

  // Index order for the six sums: pos x, y, z, then tan x, y, z.
  logic [2:0] v_q;
  logic [2:0] en;
  logic signed [63:0] prod_q [6][4];
  logic signed [64:0] pair_q [6][2];
  logic err1_q, err2_q;
  logic signed [31:0] res_q [6];
  logic               stat_q;
  logic signed [31:0] res_d [6];

  assign en[2] = !v_q[2] || out_ready_i;
  assign en[1] = !v_q[1] || en[2];
  assign en[0] = !v_q[0] || en[1];
  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      if (en[1]) v_q[1] <= v_q[0];
      if (en[2]) v_q[2] <= v_q[1];
    end
  end

  // Final sum, rounding to Q16.16 and saturation.
  always_comb begin
    for (int c = 0; c < 6; c++) begin
      logic signed [65:0] tot;
      logic signed [35:0] q;
      tot = 66'(pair_q[c][0]) + 66'(pair_q[c][1]) + (66'sd1 <<< 29);
      q   = 36'(tot >>> 30);
      if (err2_q) begin
        res_d[c] = '0;
      end else if (q > 36'sd2147483647) begin
        res_d[c] = 32'sh7fffffff;
      end else if (q < -36'sd2147483648) begin
        res_d[c] = 32'sh80000000;
      end else begin
        res_d[c] = q[31:0];
      end
    end
  end

  // Elements of a packed weight array select as unsigned, so both factors are
  // made signed before the multiply.
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int k = 0; k < 4; k++) begin
        prod_q[0][k] <= $signed(in_i.wp[k]) * $signed(in_i.pts[k].x);
        prod_q[1][k] <= $signed(in_i.wp[k]) * $signed(in_i.pts[k].y);
        prod_q[2][k] <= $signed(in_i.wp[k]) * $signed(in_i.pts[k].z);
        prod_q[3][k] <= $signed(in_i.wd[k]) * $signed(in_i.pts[k].x);
        prod_q[4][k] <= $signed(in_i.wd[k]) * $signed(in_i.pts[k].y);
        prod_q[5][k] <= $signed(in_i.wd[k]) * $signed(in_i.pts[k].z);
      end
      err1_q <= in_i.err;
    end
    if (en[1]) begin
      for (int c = 0; c < 6; c++) begin
        pair_q[c][0] <= 65'(prod_q[c][0]) + 65'(prod_q[c][1]);
        pair_q[c][1] <= 65'(prod_q[c][2]) + 65'(prod_q[c][3]);
      end
      err2_q <= err1_q;
    end
    if (en[2]) begin
      res_q  <= res_d;
      stat_q <= err2_q ? StatErr : StatOk;
    end
  end

  assign out_valid_o = v_q[2];
  assign out_o.pos_x = res_q[0];
  assign out_o.pos_y = res_q[1];
  assign out_o.pos_z = res_q[2];
  assign out_o.tan_x = res_q[3];
  assign out_o.tan_y = res_q[4];
  assign out_o.tan_z = res_q[5];
  assign status_o    = stat_q;

endmodule

### tb/sv/bspline_checker.sv
// Watches both stream channels of the spline evaluator, predicts each result
// from its own copy of the point table and num_points, and compares results.
module bspline_checker import cbs_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [6:0]   cfg_wdata_i,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,
  input  logic         s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [191:0] m_axis_tdata,
  input  logic         m_axis_tuser,
  output int           fail_count,
  output int           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    res_t  vals;
    stat_e st;
  } curve_res_t;

  logic signed [31:0] tab_x [MaxPoints];
  logic signed [31:0] tab_y [MaxPoints];
  logic signed [31:0] tab_z [MaxPoints];
  logic [6:0]         npoints;
  curve_res_t         curve_q [$];

  assign pending = curve_q.size();

  // Round a Q2.30 x Q16.16 accumulator to Q16.16 and saturate.
  function automatic logic signed [31:0] round_sat(longint acc);
    longint q;
    q = (acc + (64'sd1 <<< 29)) >>> 30;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q[31:0];
  endfunction

  function automatic curve_res_t eval_curve(logic [5:0] seg, logic [15:0] t);
    curve_res_t r;
    longint u, s, lim;
    longint a [4];
    longint d [4];
    longint wp [4];
    longint wd [4];
    longint acc [6];
    r.vals = '0;
    r.st = StatErr;
    lim = (npoints < MaxPoints) ? npoints : MaxPoints;
    if (seg < 1 || longint'(seg) + 3 > lim) return r;
    u = t;
    s = 65536 - u;
    a[0] = s * s * s;
    a[1] = 3 * u * u * u - 6 * u * u * 65536 + 4 * (64'sd1 <<< 48);
    a[2] = -3 * u * u * u + 3 * u * u * 65536 + 3 * u * (64'sd1 <<< 32) + (64'sd1 <<< 48);
    a[3] = u * u * u;
    d[0] = -(s * s);
    d[1] = 3 * u * u - 4 * u * 65536;
    d[2] = -3 * u * u + 2 * u * 65536 + (64'sd1 <<< 32);
    d[3] = u * u;
    for (int k = 0; k < 6; k++) acc[k] = 0;
    for (int k = 0; k < 4; k++) begin
      // Position basis terms are never negative, so truncation is a floor.
      wp[k] = (a[k] + 3 * (64'sd1 <<< 18)) / (6 * (64'sd1 <<< 18));
      wd[k] = (d[k] + 4) >>> 3;
      acc[0] += wp[k] * longint'(tab_x[seg - 1 + k]);
      acc[1] += wp[k] * longint'(tab_y[seg - 1 + k]);
      acc[2] += wp[k] * longint'(tab_z[seg - 1 + k]);
      acc[3] += wd[k] * longint'(tab_x[seg - 1 + k]);
      acc[4] += wd[k] * longint'(tab_y[seg - 1 + k]);
      acc[5] += wd[k] * longint'(tab_z[seg - 1 + k]);
    end
    r.vals.pos_x = round_sat(acc[0]);
    r.vals.pos_y = round_sat(acc[1]);
    r.vals.pos_z = round_sat(acc[2]);
    r.vals.tan_x = round_sat(acc[3]);
    r.vals.tan_y = round_sat(acc[4]);
    r.vals.tan_z = round_sat(acc[5]);
    r.st = StatOk;
    return r;
  endfunction

  function automatic int field_bad(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v === act_v) return 0;
    $error("%s: expected %0d (0x%08h), got %0d (0x%08h)", name,
           $signed(exp_v), exp_v, $signed(act_v), act_v);
    return 1;
  endfunction

  // Track input beats and configuration, check output beats.
  always @(posedge clk_i or negedge rst_ni) begin
    curve_res_t want;
    res_t       got;
    int         bad;
    if (!rst_ni) begin
      npoints <= NumPointsReset;
      fail_count <= 0;
      curve_q.delete();
    end else begin
      if (cfg_we_i) npoints <= cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) begin
        if (cmd_e'(s_axis_tuser) == CmdWrite) begin
          tab_x[s_axis_tdata[5:0]] = s_axis_tdata[37:6];
          tab_y[s_axis_tdata[5:0]] = s_axis_tdata[69:38];
          tab_z[s_axis_tdata[5:0]] = s_axis_tdata[101:70];
        end else begin
          curve_q = {curve_q,
                     eval_curve(s_axis_tdata[107:102], s_axis_tdata[123:108])};
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (curve_q.size() == 0) begin
          $error("result beat with no evaluate pending");
          fail_count <= fail_count + 1;
        end else begin
          want = curve_q.pop_front();
          got = m_axis_tdata;
          bad = 0;
          bad += field_bad("pos_x", want.vals.pos_x, got.pos_x);
          bad += field_bad("pos_y", want.vals.pos_y, got.pos_y);
          bad += field_bad("pos_z", want.vals.pos_z, got.pos_z);
          bad += field_bad("tan_x", want.vals.tan_x, got.tan_x);
          bad += field_bad("tan_y", want.vals.tan_y, got.tan_y);
          bad += field_bad("tan_z", want.vals.tan_z, got.tan_z);
          bad += field_bad("status", 32'(want.st), 32'(m_axis_tuser));
          if (bad != 0) fail_count <= fail_count + 1;
        end
      end
    end
  end
endmodule

### tb/sv/tb_top.sv
module tb_top import cbs_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit = 5000;
  localparam int Latency    = 9;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [6:0]   cfg_wdata_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [191:0] m_axis_tdata;
  logic         m_axis_tuser;
  int           fail_count;
  int           pending;
  bit           calm = 1'b0;
  int           idle_cnt = 0;

  always #4 clk_i = ~clk_i;

  cubic_bspline_point_tangent DUT (.*);

  bspline_checker u_checker (.*);

  // Result side: random stall bursts, none once the run turns calm.
  always @(posedge clk_i) begin
    int n;
    if (!calm && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 11);
      m_axis_tready <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    m_axis_tready <= 1'b1;
  end

  // Ends the run if nothing moves for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_ni)
      idle_cnt <= 0;
    else if (idle_cnt >= StallLimit) begin
      $display("tb_top: errors");
      $finish;
    end else
      idle_cnt <= idle_cnt + 1;
  end

  task automatic send_beat(cmd_e cmd, logic [5:0] idx, logic [31:0] x, logic [31:0] y,
                           logic [31:0] z, logic [5:0] seg, logic [15:0] t);
    int n;
    if (!calm && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 11);
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {4'b0, t, seg, z, y, x, idx};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic write_point(logic [5:0] idx, logic [31:0] x, logic [31:0] y, logic [31:0] z);
    send_beat(CmdWrite, idx, x, y, z, 6'($urandom), 16'($urandom));
  endtask

  task automatic eval_at(logic [5:0] seg, logic [15:0] t);
    send_beat(CmdEval, 6'($urandom), $urandom, $urandom, $urandom, seg, t);
  endtask

  // Waits out every pending result, then sets num_points while idle.
  task automatic drain_and_config(logic [6:0] np);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (Latency + 3) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= np;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      2:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
    endcase
  endfunction

  initial begin
    logic [6:0] np_set [7] = '{7'd64, 7'd127, 7'd0, 7'd3, 7'd4, 7'd17, 7'd64};
    logic [6:0] np;
    int seg_hi;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extreme points in slots 0..3, then edges of t and segment.
    write_point(6'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
    write_point(6'd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    write_point(6'd2, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
    write_point(6'd3, 32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_AAAA);
    eval_at(6'd1, 16'h0000);
    eval_at(6'd1, 16'hFFFF);
    eval_at(6'd1, 16'h8000);
    eval_at(6'd0, 16'h1234);
    eval_at(6'd2, 16'h4000);
    eval_at(6'd63, 16'hFFFF);
    // A point read by the very next beat.
    write_point(6'd2, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    eval_at(6'd1, 16'hC000);
    write_point(6'd1, 32'h0002_0000, 32'hFFFE_0000, 32'h0000_8000);
    eval_at(6'd1, 16'h0001);

    // Fill the whole table so every segment reads written points.
    for (int i = 0; i < MaxPoints; i++) write_point(6'(i), rand_coord(), rand_coord(),
                                                    rand_coord());

    for (int ph = 0; ph < 7; ph++) begin
      np = np_set[ph];
      if (ph == 6) np = 7'($urandom_range(4, 64));
      drain_and_config(np);
      if (ph == 6) calm = 1'b1;
      seg_hi = (np < MaxPoints ? int'(np) : MaxPoints) - 3;
      for (int i = 0; i < 220; i++) begin
        if ($urandom_range(0, 3) == 0)
          write_point(6'($urandom), rand_coord(), rand_coord(), rand_coord());
        else if (seg_hi >= 1 && $urandom_range(0, 7) != 0)
          eval_at(6'($urandom_range(1, seg_hi)), 16'($urandom));
        else
          eval_at(6'($urandom), $urandom_range(0, 1) ? 16'($urandom) : 16'hFFFF);
      end
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
    if (fail_count == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end
endmodule

### filelist.f
sv/cbs_pkg.sv
sv/cbs_point_mem.sv
sv/cbs_weights.sv
sv/cbs_blend.sv
sv/cubic_bspline_point_tangent.sv
tb/sv/bspline_checker.sv
tb/sv/tb_top.sv
